[rtl/sacl_pkg.sv]
// Shared types and constants for the set-associative cache tag store.
// Used by every module under rtl/ except sacl_ram; depends on nothing.
package sacl_pkg;

    // Cache geometry (all three are powers of two)
    localparam int NUM_SETS   = 16;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 8;

    // Field widths
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 64;
    localparam int LINE_W  = 29;
    localparam int CNT_W   = 64;

    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int LINE_SHIFT = $clog2(LINE_BYTES);

    // Stream word widths, padded to whole bytes (op travels on tuser)
    localparam int S_DATA_W = ((ADDR_W + STAMP_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 + LINE_W + STAMP_W + 3 * CNT_W + 7) / 8) * 8;

    // Operation codes
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_ACCESS = 2'd0;
    localparam op_t OP_INVAL  = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

    // One way of a set, and one set row as held in the tag RAM
    typedef struct packed {
        logic [LINE_W-1:0]  line;
        logic [STAMP_W-1:0] stamp;
    } way_ent_t;

    typedef way_ent_t [NUM_WAYS-1:0] set_row_t;

    localparam int ROW_W = $bits(set_row_t);

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch the input word, start the set read
        logic look;      // tag compare and hit / invalidate / clear updates
        logic scan;      // one step of the victim search
        logic fill;      // write the victim way
        logic out_load;  // capture the result word
    } sacl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;  // access that missed
        logic scan_stop;  // current scan step is the last one
    } sacl_sts_t;

endpackage

[rtl/sacl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while re is low
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sacl_ctrl.sv]
// Sequencing state machine for the cache tag store.
// Depends on sacl_pkg; drives sacl_dp through command / status structs.
module sacl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output sacl_pkg::sacl_cmd_t cmd,
    input  sacl_pkg::sacl_sts_t sts
);
    import sacl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_SCAN = 5'b00100,
        S_FILL = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.look   = 1'b1;
                state_next = sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_stop) begin
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cmd.fill   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[rtl/sacl_dp.sv]
// Datapath of the cache tag store: tag RAM, valid bits, victim scan,
// counters and the output word. Depends on sacl_pkg and sacl_ram.
module sacl_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sacl_pkg::OP_W-1:0]     s_tuser,
    input  logic [sacl_pkg::S_DATA_W-1:0] s_tdata,
    input  sacl_pkg::sacl_cmd_t           cmd,
    output sacl_pkg::sacl_sts_t           sts,
    output logic [sacl_pkg::M_DATA_W-1:0] m_tdata
);
    import sacl_pkg::*;

    // input word fields
    op_t                op_in;
    logic [ADDR_W-1:0]  addr_in;
    logic [STAMP_W-1:0] now_in;
    logic [ADDR_W-1:0]  line_in;
    logic [SET_W-1:0]   set_in;

    // latched item
    op_t                op_reg;
    logic [SET_W-1:0]   set_reg;
    logic [LINE_W-1:0]  tag_reg;
    logic [STAMP_W-1:0] now_reg;

    // per-entry flags: valid, and written since the last clear
    logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_reg;
    logic [NUM_SETS-1:0][NUM_WAYS-1:0] init_reg;

    // tag RAM
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_we;
    set_row_t         row;
    set_row_t         row_upd;

    // lookup
    logic [NUM_WAYS-1:0] hit_vec;
    logic                tag_hit;
    logic [WAY_W-1:0]    hit_way;

    // victim scan
    logic [WAY_W-1:0]   way_cnt_reg;
    logic [WAY_W-1:0]   pick_reg;
    logic [STAMP_W-1:0] bound_reg;
    logic               full_reg;
    logic               cur_valid;
    logic [STAMP_W-1:0] cur_stamp;

    // sticky victim record and counters
    logic               last_full_reg;
    logic [LINE_W-1:0]  victim_line_reg;
    logic [STAMP_W-1:0] victim_stamp_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [CNT_W-1:0]   miss_cnt_reg;
    logic [CNT_W-1:0]   access_cnt_reg;
    logic               hit_out_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // split the input word, derive line and set
    assign op_in   = s_tuser;
    assign addr_in = s_tdata[ADDR_W-1:0];
    assign now_in  = s_tdata[ADDR_W +: STAMP_W];
    assign line_in = addr_in >> LINE_SHIFT;
    assign set_in  = SET_W'(line_in & ADDR_W'(NUM_SETS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= op_in;
            set_reg <= set_in;
            tag_reg <= line_in[LINE_W-1:0];
            now_reg <= now_in;
        end
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (set_in),
        .rdata (ram_rdata)
    );

    assign row = set_row_t'(ram_rdata);

    // tag compare across the set, lowest matching way wins
    always_comb begin
        hit_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            hit_vec[w] = valid_reg[set_reg][w] && (row[w].line == tag_reg);
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
        end
    end

    assign tag_hit = |hit_vec;

    // current scan step
    assign cur_valid = valid_reg[set_reg][way_cnt_reg];
    assign cur_stamp = row[way_cnt_reg].stamp;

    assign sts.need_scan = (op_reg == OP_ACCESS) && !tag_hit;
    assign sts.scan_stop = !cur_valid || (way_cnt_reg == WAY_W'(NUM_WAYS - 1));

    // row write-back: restamp on a hit, new line on a fill
    always_comb begin
        row_upd = row;
        ram_we  = 1'b0;
        if (cmd.look && (op_reg == OP_ACCESS) && tag_hit) begin
            row_upd[hit_way].stamp = now_reg;
            ram_we                 = 1'b1;
        end else if (cmd.fill) begin
            row_upd[pick_reg].line  = tag_reg;
            row_upd[pick_reg].stamp = now_reg;
            ram_we                  = 1'b1;
        end
    end

    assign ram_wdata = ROW_W'(row_upd);

    // victim search, one way per cycle; ties go to the higher way
    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            way_cnt_reg <= '0;
            pick_reg    <= '0;
            bound_reg   <= now_reg;
            full_reg    <= 1'b1;
        end else if (cmd.scan) begin
            way_cnt_reg <= way_cnt_reg + 1'b1;
            if (!cur_valid) begin
                pick_reg <= way_cnt_reg;
                full_reg <= 1'b0;
            end else if (cur_stamp <= bound_reg) begin
                pick_reg  <= way_cnt_reg;
                bound_reg <= cur_stamp;
            end
        end
    end

    // flags, victim record and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            init_reg         <= '0;
            last_full_reg    <= 1'b0;
            victim_line_reg  <= '0;
            victim_stamp_reg <= '0;
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            access_cnt_reg   <= '0;
            hit_out_reg      <= 1'b0;
        end else begin
            if (cmd.look) begin
                hit_out_reg <= tag_hit &&
                               ((op_reg == OP_ACCESS) || (op_reg == OP_INVAL));
                if (op_reg == OP_ACCESS) begin
                    access_cnt_reg <= access_cnt_reg + 1'b1;
                    if (tag_hit) begin
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                    end else begin
                        miss_cnt_reg <= miss_cnt_reg + 1'b1;
                    end
                end
                if ((op_reg == OP_INVAL) && tag_hit) begin
                    valid_reg[set_reg][hit_way] <= 1'b0;
                end
                if (op_reg == OP_CLEAR) begin
                    valid_reg      <= '0;
                    init_reg       <= '0;
                    hit_cnt_reg    <= '0;
                    miss_cnt_reg   <= '0;
                    access_cnt_reg <= '0;
                end
            end
            if (cmd.fill) begin
                last_full_reg <= full_reg;
                // a way never written since the last clear reads as zero
                if (init_reg[set_reg][pick_reg]) begin
                    victim_line_reg  <= row[pick_reg].line;
                    victim_stamp_reg <= row[pick_reg].stamp;
                end else begin
                    victim_line_reg  <= '0;
                    victim_stamp_reg <= '0;
                end
                valid_reg[set_reg][pick_reg] <= 1'b1;
                init_reg[set_reg][pick_reg]  <= 1'b1;
            end
        end
    end

    // output word
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= M_DATA_W'({access_cnt_reg, miss_cnt_reg, hit_cnt_reg,
                                     victim_stamp_reg, victim_line_reg,
                                     last_full_reg, hit_out_reg});
        end
    end

    assign m_tdata = m_data_reg;

    // every access is either a hit or a miss
    a_cnt_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        access_cnt_reg == hit_cnt_reg + miss_cnt_reg)
        else $error("access count differs from hits plus misses");

    // a valid way has always been written since the last clear
    a_valid_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg & ~init_reg) == '0)
        else $error("valid way without written contents");

    // the scan bound only moves down from the access time
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> (bound_reg <= now_reg))
        else $error("victim bound above access time");

    // a filled way is valid afterwards
    a_fill_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill |=> valid_reg[set_reg][pick_reg])
        else $error("filled way not valid");

endmodule

[rtl/set_assoc_cache_lru_lookup.sv]
// Set-associative tag store with time-stamp LRU replacement.
// The result is registered: a hit, invalidate or clear passes the set read, the
// compare and the result load; a miss adds the victim scan and a fill before the load.
// Throughput: one item at a time; the next word is taken only after the result load
// (set read, compare, result load), which waits while the output register is full.
// Reset (aresetn low, synchronous) empties all ways and zeroes counters and record.
module set_assoc_cache_lru_lookup (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tuser: op[1:0]
    input  logic [sacl_pkg::OP_W-1:0]     s_tuser,
    // tdata: address[31:0], now[95:32]
    input  logic [sacl_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: hit[0], set_was_full[1], victim_line[30:2], victim_stamp[94:31],
    //        hit_total[158:95], miss_total[222:159], access_total[286:223], pad
    output logic [sacl_pkg::M_DATA_W-1:0] m_tdata
);
    import sacl_pkg::*;

    sacl_cmd_t cmd;
    sacl_sts_t sts;

    sacl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    sacl_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule
